// ----- rtl/gpt_pkg.sv -----
// Shared types, codes and constants for the game port pulse timer.
package gpt_pkg;

    // Field and register widths.
    localparam int TIMEOUT_W   = 14;
    localparam int POS_W       = 32;
    localparam int SAMPLE_W    = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Register defaults and limits.
    localparam int MAX_TIMEOUT_DEF = 10000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 14'd2000;
    localparam logic [POS_W-1:0]     NO_AXIS       = 32'h8000_0000;
    localparam logic [3:0]           AXIS_NIBBLE   = 4'hf;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_P0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_P1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFF_P0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFF_P0   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFF_P1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFF_P1   = 3'd5;

    // Input function codes.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Result kinds.
    localparam logic KIND_FIRE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Reading phase.
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SETTLE  = 2'd1,
        PH_MEASURE = 2'd2
    } phase_t;

    // Register file contents, indexed by joystick part.
    typedef struct packed {
        logic [1:0][TIMEOUT_W-1:0] timeout;
        logic [1:0][POS_W-1:0]     x_offset;
        logic [1:0][POS_W-1:0]     y_offset;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic                    kind;
        logic signed [POS_W-1:0] x_position;
        logic signed [POS_W-1:0] y_position;
        logic                    button_one;
        logic                    button_two;
    } res_t;

endpackage

// ----- rtl/gpt_cfg_regs.sv -----
// Configuration register file for the game port pulse timer.
module gpt_cfg_regs #(
    parameter int MAX_TIMEOUT = gpt_pkg::MAX_TIMEOUT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output gpt_pkg::cfg_t                    cfg
);

    gpt_pkg::cfg_t cfg_reg;
    gpt_pkg::cfg_t cfg_next;
    logic [gpt_pkg::TIMEOUT_W-1:0] wr_timeout;
    logic                          timeout_ok;

    // A timeout write outside one to the maximum leaves the register alone.
    assign wr_timeout = cfg_data[gpt_pkg::TIMEOUT_W-1:0];
    assign timeout_ok = (wr_timeout != '0) &&
                        (wr_timeout <= gpt_pkg::TIMEOUT_W'(MAX_TIMEOUT));

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                gpt_pkg::REG_TIMEOUT_P0:
                begin
                    if (timeout_ok)
                        cfg_next.timeout[0] = wr_timeout;
                end
                gpt_pkg::REG_TIMEOUT_P1:
                begin
                    if (timeout_ok)
                        cfg_next.timeout[1] = wr_timeout;
                end
                gpt_pkg::REG_X_OFF_P0: cfg_next.x_offset[0] = cfg_data;
                gpt_pkg::REG_Y_OFF_P0: cfg_next.y_offset[0] = cfg_data;
                gpt_pkg::REG_X_OFF_P1: cfg_next.x_offset[1] = cfg_data;
                gpt_pkg::REG_Y_OFF_P1: cfg_next.y_offset[1] = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout[0]  <= gpt_pkg::TIMEOUT_RESET;
            cfg_reg.timeout[1]  <= gpt_pkg::TIMEOUT_RESET;
            cfg_reg.x_offset[0] <= '0;
            cfg_reg.x_offset[1] <= '0;
            cfg_reg.y_offset[0] <= '0;
            cfg_reg.y_offset[1] <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/gpt_core.sv -----
// Reading state and per-item result logic of the game port pulse timer.
module gpt_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic                             func,
    input  logic                             part,
    input  logic [gpt_pkg::SAMPLE_W-1:0]     sample,
    input  gpt_pkg::cfg_t                    cfg,
    output logic                             res_valid,
    output gpt_pkg::res_t                    res
);

    gpt_pkg::phase_t phase_reg, phase_next;
    logic                            active_part_reg, active_part_next;
    logic [gpt_pkg::TIMEOUT_W-1:0]   tick_count_reg, tick_count_next;
    logic [gpt_pkg::TIMEOUT_W-1:0]   x_count_reg, x_count_next;
    logic [gpt_pkg::TIMEOUT_W-1:0]   y_count_reg, y_count_next;
    logic                            x_seen_reg, x_seen_next;
    logic                            y_seen_reg, y_seen_next;
    logic [gpt_pkg::SAMPLE_W-1:0]    last_sample_reg, last_sample_next;

    logic [gpt_pkg::TIMEOUT_W-1:0]   limit;
    logic [gpt_pkg::TIMEOUT_W-1:0]   tick_inc;
    logic [gpt_pkg::SAMPLE_W-1:0]    part_sample;
    logic                            axes_quiet;
    logic                            limit_hit;
    logic                            settle_fire;
    logic                            x_low_new;
    logic                            y_low_new;
    logic                            measure_done;
    logic                            is_tick;

    // Shared decode of the current tick.
    assign is_tick     = step && (func == gpt_pkg::FUNC_TICK);
    assign limit       = cfg.timeout[active_part_reg];
    assign tick_inc    = tick_count_reg + 1'b1;
    assign limit_hit   = tick_inc >= limit;
    assign axes_quiet  = (sample & gpt_pkg::SAMPLE_W'(gpt_pkg::AXIS_NIBBLE)) == '0;
    assign settle_fire = axes_quiet || limit_hit;
    assign part_sample = active_part_reg ? (sample >> 2) : sample;
    assign x_low_new   = !x_seen_reg && !part_sample[0];
    assign y_low_new   = !y_seen_reg && !part_sample[1];
    assign measure_done = ((x_seen_reg || x_low_new) && (y_seen_reg || y_low_new)) ||
                          limit_hit;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            if (func == gpt_pkg::FUNC_START)
                phase_next = gpt_pkg::PH_SETTLE;
            else
            begin
                unique case (phase_reg)
                    gpt_pkg::PH_SETTLE:
                    begin
                        if (settle_fire)
                            phase_next = gpt_pkg::PH_MEASURE;
                    end
                    gpt_pkg::PH_MEASURE:
                    begin
                        if (measure_done)
                            phase_next = gpt_pkg::PH_IDLE;
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    // Counters, latches and result.
    always_comb
    begin
        active_part_next = active_part_reg;
        tick_count_next  = tick_count_reg;
        x_count_next     = x_count_reg;
        y_count_next     = y_count_reg;
        x_seen_next      = x_seen_reg;
        y_seen_next      = y_seen_reg;
        last_sample_next = last_sample_reg;
        res_valid        = 1'b0;
        res              = '0;
        if (step)
        begin
            if (func == gpt_pkg::FUNC_START)
            begin
                active_part_next = part;
                tick_count_next  = '0;
                x_count_next     = '0;
                y_count_next     = '0;
                x_seen_next      = 1'b0;
                y_seen_next      = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    gpt_pkg::PH_SETTLE:
                    begin
                        if (settle_fire)
                        begin
                            tick_count_next = '0;
                            x_count_next    = '0;
                            y_count_next    = '0;
                            x_seen_next     = 1'b0;
                            y_seen_next     = 1'b0;
                            res_valid       = 1'b1;
                            res.kind        = gpt_pkg::KIND_FIRE;
                        end
                        else
                            tick_count_next = tick_inc;
                    end
                    gpt_pkg::PH_MEASURE:
                    begin
                        last_sample_next = sample;
                        tick_count_next  = tick_inc;
                        if (x_low_new)
                        begin
                            x_seen_next  = 1'b1;
                            x_count_next = tick_inc;
                        end
                        if (y_low_new)
                        begin
                            y_seen_next  = 1'b1;
                            y_count_next = tick_inc;
                        end
                        if (measure_done)
                        begin
                            res_valid  = 1'b1;
                            res.kind   = gpt_pkg::KIND_DONE;
                            res.x_position = x_seen_next ?
                                (cfg.x_offset[active_part_reg] +
                                 gpt_pkg::POS_W'(x_count_next)) : gpt_pkg::NO_AXIS;
                            res.y_position = y_seen_next ?
                                (cfg.y_offset[active_part_reg] +
                                 gpt_pkg::POS_W'(y_count_next)) : gpt_pkg::NO_AXIS;
                            // Buttons are active low on the port.
                            res.button_one = ~part_sample[4];
                            res.button_two = ~part_sample[5];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= gpt_pkg::PH_IDLE;
            active_part_reg <= 1'b0;
            tick_count_reg  <= '0;
            x_count_reg     <= '0;
            y_count_reg     <= '0;
            x_seen_reg      <= 1'b0;
            y_seen_reg      <= 1'b0;
            last_sample_reg <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            active_part_reg <= active_part_next;
            tick_count_reg  <= tick_count_next;
            x_count_reg     <= x_count_next;
            y_count_reg     <= y_count_next;
            x_seen_reg      <= x_seen_next;
            y_seen_reg      <= y_seen_next;
            last_sample_reg <= last_sample_next;
        end
    end

    // A tick with no reading under way never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (is_tick && phase_reg == gpt_pkg::PH_IDLE) |-> !res_valid)
        else $error("result produced while idle");

    // Completion results come only from the measure phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == gpt_pkg::KIND_DONE) |-> phase_reg == gpt_pkg::PH_MEASURE)
        else $error("done result outside measure phase");

    // A completed reading leaves the block idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == gpt_pkg::KIND_DONE) |=> phase_reg == gpt_pkg::PH_IDLE)
        else $error("phase not idle after done");

    // A start always opens a fresh settle phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && func == gpt_pkg::FUNC_START) |=>
        (phase_reg == gpt_pkg::PH_SETTLE && !x_seen_reg && !y_seen_reg && tick_count_reg == '0))
        else $error("start did not clear the reading");

endmodule

// ----- rtl/game_port_axis_pulse_timer.sv -----
// Top level of the game port pulse timer: input and result registers around the core.
// A result passes through the input register and then the result register before the master side offers it.
// Throughput: one input transfer per cycle while results are taken; the state
// update and position add sit between the input register and the result register.
// Reset: rst_n clears the reading state to idle, empties both registers and
// loads timeouts of 2000 us and zero offsets.
module game_port_axis_pulse_timer #(
    parameter int MAX_TIMEOUT = gpt_pkg::MAX_TIMEOUT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [15:0]                      s_axis_tdata,  // part, port_sample, zero pad
    input  logic                             s_axis_tuser,  // func
    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [71:0]                      m_axis_tdata,  // x_position, y_position,
                                                            // button_one, button_two, zero pad
    output logic                             m_axis_tuser,  // kind
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [gpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gpt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    gpt_pkg::cfg_t cfg;
    gpt_pkg::res_t res;
    gpt_pkg::res_t out_res_reg;
    logic          res_valid;

    logic                          in_valid_reg, in_valid_next;
    logic                          in_func_reg;
    logic                          in_part_reg;
    logic [gpt_pkg::SAMPLE_W-1:0]  in_sample_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          s_xfer;
    logic                          advance;

    // Handshake control: the held item moves on when the result register frees up.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? res_valid :
                            (m_axis_tready ? 1'b0 : out_valid_reg);

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_func_reg   <= s_axis_tuser;
            in_part_reg   <= s_axis_tdata[0];
            in_sample_reg <= s_axis_tdata[gpt_pkg::SAMPLE_W:1];
        end
        if (advance && res_valid)
            out_res_reg <= res;
    end

    gpt_cfg_regs #(
        .MAX_TIMEOUT (MAX_TIMEOUT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gpt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .func      (in_func_reg),
        .part      (in_part_reg),
        .sample    (in_sample_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tdata  = {6'b0, out_res_reg.button_two, out_res_reg.button_one,
                            out_res_reg.y_position, out_res_reg.x_position};

endmodule

// ----- tb/game_port_axis_pulse_timer_tb.sv -----
// Self-checking testbench for the game port pulse timer: stream stimulus, scoreboard and checks.
`timescale 1ns / 100ps

module game_port_axis_pulse_timer_tb;

    // Register indexes that decode to no register.
    localparam logic [gpt_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [gpt_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // Cycles to let the pipeline settle before a register write or the end.
    localparam int DRAIN_CYCLES = 8;
    // Length of the receiver hold-off that backs up the block.
    localparam int HOLD_CYCLES  = 80;
    // Input transfers per random phase.
    localparam int PHASE_ITEMS  = 65;

    // Scoreboard: tracks the reading state and queues the results it predicts.
    class pulse_timer_scoreboard;
        logic [gpt_pkg::TIMEOUT_W-1:0] timeout [2];
        logic [gpt_pkg::POS_W-1:0]     x_offset [2];
        logic [gpt_pkg::POS_W-1:0]     y_offset [2];
        gpt_pkg::phase_t               phase;
        logic                          active_part;
        logic [gpt_pkg::TIMEOUT_W-1:0] tick_count;
        logic [gpt_pkg::TIMEOUT_W-1:0] x_count;
        logic [gpt_pkg::TIMEOUT_W-1:0] y_count;
        logic                          x_seen;
        logic                          y_seen;
        gpt_pkg::res_t                 expected_results [$];
        int                            errors;

        function new();
            timeout[0]  = gpt_pkg::TIMEOUT_RESET;
            timeout[1]  = gpt_pkg::TIMEOUT_RESET;
            x_offset[0] = '0;
            x_offset[1] = '0;
            y_offset[0] = '0;
            y_offset[1] = '0;
            phase       = gpt_pkg::PH_IDLE;
            active_part = 1'b0;
            clear_counts();
            errors      = 0;
        endfunction

        function void clear_counts();
            tick_count = '0;
            x_count    = '0;
            y_count    = '0;
            x_seen     = 1'b0;
            y_seen     = 1'b0;
        endfunction

        // Mirror a register write; out-of-range timeouts and spare indexes are dropped.
        function void write_reg(logic [gpt_pkg::CFG_IDX_W-1:0] idx,
                                logic [gpt_pkg::CFG_DATA_W-1:0] value);
            logic [gpt_pkg::TIMEOUT_W-1:0] t;
            t = value[gpt_pkg::TIMEOUT_W-1:0];
            case (idx)
                gpt_pkg::REG_TIMEOUT_P0, gpt_pkg::REG_TIMEOUT_P1:
                    if (t >= 1 && t <= gpt_pkg::MAX_TIMEOUT_DEF)
                        timeout[idx[0]] = t;
                gpt_pkg::REG_X_OFF_P0: x_offset[0] = value;
                gpt_pkg::REG_Y_OFF_P0: y_offset[0] = value;
                gpt_pkg::REG_X_OFF_P1: x_offset[1] = value;
                gpt_pkg::REG_Y_OFF_P1: y_offset[1] = value;
                default: ;
            endcase
        endfunction

        // Advance the reading by one accepted input transfer.
        function void note_input(logic func, logic part, logic [gpt_pkg::SAMPLE_W-1:0] sample);
            logic [gpt_pkg::TIMEOUT_W-1:0] limit;
            logic [gpt_pkg::SAMPLE_W-1:0]  bits;
            gpt_pkg::res_t                 r;
            if (func == gpt_pkg::FUNC_START)
            begin
                active_part = part;
                phase       = gpt_pkg::PH_SETTLE;
                clear_counts();
                return;
            end
            limit = timeout[active_part];
            r     = '0;
            if (phase == gpt_pkg::PH_SETTLE)
            begin
                // A quiet axis nibble fires at once; otherwise wait for the timeout.
                if (sample[3:0] != 4'h0)
                begin
                    tick_count = tick_count + 1'b1;
                    if (tick_count < limit)
                        return;
                end
                phase  = gpt_pkg::PH_MEASURE;
                clear_counts();
                r.kind = gpt_pkg::KIND_FIRE;
                expected_results.push_back(r);
            end
            else if (phase == gpt_pkg::PH_MEASURE)
            begin
                bits       = active_part ? (sample >> 2) : sample;
                tick_count = tick_count + 1'b1;
                if (!x_seen && !bits[0])
                begin
                    x_seen  = 1'b1;
                    x_count = tick_count;
                end
                if (!y_seen && !bits[1])
                begin
                    y_seen  = 1'b1;
                    y_count = tick_count;
                end
                if ((x_seen && y_seen) || tick_count >= limit)
                begin
                    phase        = gpt_pkg::PH_IDLE;
                    r.kind       = gpt_pkg::KIND_DONE;
                    r.x_position = x_seen ? x_offset[active_part] + {18'b0, x_count} :
                                            gpt_pkg::NO_AXIS;
                    r.y_position = y_seen ? y_offset[active_part] + {18'b0, y_count} :
                                            gpt_pkg::NO_AXIS;
                    r.button_one = ~bits[4];
                    r.button_two = ~bits[5];
                    expected_results.push_back(r);
                end
            end
        endfunction

        function void compare_field(string name, logic [gpt_pkg::POS_W-1:0] want,
                                    logic [gpt_pkg::POS_W-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        // Compare one result transfer with the oldest prediction.
        function void check_result(logic kind, logic [71:0] data);
            gpt_pkg::res_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: kind %0d", kind);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("kind", want.kind, kind);
            compare_field("x_position", want.x_position, data[31:0]);
            compare_field("y_position", want.y_position, data[63:32]);
            compare_field("button_one", want.button_one, data[64]);
            compare_field("button_two", want.button_two, data[65]);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic                           cfg_we;
    logic [gpt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gpt_pkg::CFG_DATA_W-1:0] cfg_data;

    pulse_timer_scoreboard sb;
    int sent_items;
    bit gaps_on;
    bit ready_steady;
    bit hold_request;

    game_port_axis_pulse_timer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog for a hung run.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Monitor both streams on every rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[8:1]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    // Result receiver: random back-pressure, plus a long hold-off on request.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_axis_tready <= ready_steady || ($urandom_range(99, 0) >= 20);
        end
    end

    // Offer one input item and wait for its transfer; valid stays high afterwards.
    task automatic send_item(logic func, logic part, logic [gpt_pkg::SAMPLE_W-1:0] sample);
        if (gaps_on && $urandom_range(99, 0) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {7'b0, sample, part};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_items++;
    endtask

    // Stop offering input and wait until every predicted result has arrived.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [gpt_pkg::CFG_IDX_W-1:0] idx,
                             logic [gpt_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    // One joystick reading: start, settle ticks, then measure ticks with the
    // part's axis bits falling at chosen counts. Long runs only for short limits.
    task automatic run_reading(bit force_long);
        logic [gpt_pkg::SAMPLE_W-1:0] s;
        logic part;
        int   limit;
        int   settle_len;
        int   cap;
        int   fx;
        int   fy;
        int   last_t;
        int   xb;
        part  = force_long ? 1'b0 : 1'($urandom_range(1, 0));
        limit = int'(sb.timeout[part]);
        xb    = part ? 2 : 0;
        send_item(gpt_pkg::FUNC_START, part, 8'($urandom));

        // Settle: either run out the timeout or go quiet after a few ticks.
        if (!force_long && limit <= 64 && $urandom_range(99, 0) < 15)
            settle_len = limit;
        else
            settle_len = $urandom_range((limit - 1 < 6) ? limit - 1 : 6, 0);
        for (int t = 0; t < settle_len; t++)
        begin
            s = 8'($urandom);
            if (s[3:0] == 4'h0)
                s[$urandom_range(3, 0)] = 1'b1;
            send_item(gpt_pkg::FUNC_TICK, 1'($urandom_range(1, 0)), s);
        end
        if (settle_len < limit)
        begin
            s = 8'($urandom);
            s[3:0] = 4'h0;
            send_item(gpt_pkg::FUNC_TICK, 1'($urandom_range(1, 0)), s);
        end

        // Measure: pick the count at which each axis falls, past the limit for never.
        cap = (limit < 40) ? limit : 40;
        fx  = $urandom_range(cap, 1);
        fy  = $urandom_range(cap, 1);
        if (force_long || (limit <= 64 && $urandom_range(99, 0) < 15))
            fx = limit + 1;
        if (force_long || (limit <= 64 && $urandom_range(99, 0) < 15))
            fy = limit + 1;
        last_t = (fx > fy) ? fx : fy;
        if (last_t > limit)
            last_t = limit;
        // Now and then cut the reading short; the next start aborts it.
        if (!force_long && $urandom_range(99, 0) < 8)
            last_t = $urandom_range(last_t, 1) - 1;
        for (int t = 1; t <= last_t; t++)
        begin
            s = 8'($urandom);
            if (t <= fx)
                s[xb] = (t < fx);
            if (t <= fy)
                s[xb + 1] = (t < fy);
            send_item(gpt_pkg::FUNC_TICK, 1'($urandom_range(1, 0)), s);
        end
    endtask

    // Main sequence: reset, directed cases, then random phases between register writes.
    initial
    begin
        int phase_start;
        int pick;
        sb            = new();
        sent_items    = 0;
        gaps_on       = 1'b1;
        ready_steady  = 1'b0;
        hold_request  = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= gpt_pkg::FUNC_START;
        cfg_we        <= 1'b0;
        cfg_index     <= gpt_pkg::REG_TIMEOUT_P0;
        cfg_data      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tick while idle is ignored; then quick readings at the reset settings.
        send_item(gpt_pkg::FUNC_TICK, 1'b1, 8'hff);
        send_item(gpt_pkg::FUNC_START, 1'b0, 8'h00);
        send_item(gpt_pkg::FUNC_TICK, 1'b0, 8'h00);
        send_item(gpt_pkg::FUNC_TICK, 1'b0, 8'hfe);
        send_item(gpt_pkg::FUNC_TICK, 1'b0, 8'h0d);
        // Start while settling restarts the reading for part one.
        send_item(gpt_pkg::FUNC_START, 1'b1, 8'h00);
        send_item(gpt_pkg::FUNC_START, 1'b1, 8'hff);
        send_item(gpt_pkg::FUNC_TICK, 1'b0, 8'h05);
        send_item(gpt_pkg::FUNC_TICK, 1'b1, 8'hf0);
        send_item(gpt_pkg::FUNC_TICK, 1'b0, 8'h00);
        // Start while measuring aborts without a result.
        send_item(gpt_pkg::FUNC_START, 1'b0, 8'h00);
        send_item(gpt_pkg::FUNC_TICK, 1'b0, 8'h00);
        send_item(gpt_pkg::FUNC_TICK, 1'b1, 8'hff);
        send_item(gpt_pkg::FUNC_START, 1'b0, 8'haa);
        drain();

        // Out-of-range timeouts and spare indexes are dropped; offsets at the extremes.
        cfg_write(gpt_pkg::REG_TIMEOUT_P0, 32'd0);
        cfg_write(gpt_pkg::REG_TIMEOUT_P1, 32'd10001);
        cfg_write(REG_SPARE_6, 32'hffff_ffff);
        cfg_write(REG_SPARE_7, 32'h0000_0001);
        cfg_write(gpt_pkg::REG_TIMEOUT_P0, 32'd1);
        cfg_write(gpt_pkg::REG_TIMEOUT_P1, 32'h0000_4002);
        cfg_write(gpt_pkg::REG_X_OFF_P0, 32'h7fff_ffff);
        cfg_write(gpt_pkg::REG_Y_OFF_P0, 32'h8000_0000);
        cfg_write(gpt_pkg::REG_X_OFF_P1, 32'hffff_ffff);
        cfg_write(gpt_pkg::REG_Y_OFF_P1, 32'h0000_0001);

        // Settle timeout followed by a measure timeout with no axis falling.
        send_item(gpt_pkg::FUNC_START, 1'b0, 8'h00);
        send_item(gpt_pkg::FUNC_TICK, 1'b0, 8'h0f);
        send_item(gpt_pkg::FUNC_TICK, 1'b0, 8'hff);
        // Position wraps past the top of the signed range.
        send_item(gpt_pkg::FUNC_START, 1'b0, 8'h00);
        send_item(gpt_pkg::FUNC_TICK, 1'b1, 8'h00);
        send_item(gpt_pkg::FUNC_TICK, 1'b0, 8'hfe);
        // Part one reads the upper axis and button bits.
        send_item(gpt_pkg::FUNC_START, 1'b1, 8'h00);
        send_item(gpt_pkg::FUNC_TICK, 1'b0, 8'h30);
        send_item(gpt_pkg::FUNC_TICK, 1'b1, 8'h33);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph)
                2:
                begin
                    cfg_write(gpt_pkg::REG_TIMEOUT_P0, 32'd40);
                    cfg_write(gpt_pkg::REG_TIMEOUT_P1, 32'd1);
                end
                5:
                begin
                    cfg_write(gpt_pkg::REG_TIMEOUT_P0, 32'd1);
                    cfg_write(gpt_pkg::REG_TIMEOUT_P1, 32'd10000);
                end
                6:
                begin
                    cfg_write(gpt_pkg::REG_TIMEOUT_P0, 32'd1);
                    cfg_write(gpt_pkg::REG_TIMEOUT_P1, 32'd1);
                end
                default:
                begin
                    cfg_write(gpt_pkg::REG_TIMEOUT_P0, $urandom_range(24, 1));
                    cfg_write(gpt_pkg::REG_TIMEOUT_P1, $urandom_range(24, 1));
                end
            endcase
            if (ph == 3)
            begin
                cfg_write(gpt_pkg::REG_X_OFF_P0, 32'h8000_0000);
                cfg_write(gpt_pkg::REG_Y_OFF_P0, 32'h7fff_ffff);
                cfg_write(gpt_pkg::REG_X_OFF_P1, 32'h0000_0000);
                cfg_write(gpt_pkg::REG_Y_OFF_P1, 32'hffff_ffff);
            end
            else
            begin
                cfg_write(gpt_pkg::REG_X_OFF_P0, $urandom);
                cfg_write(gpt_pkg::REG_Y_OFF_P0, $urandom);
                cfg_write(gpt_pkg::REG_X_OFF_P1, $urandom);
                cfg_write(gpt_pkg::REG_Y_OFF_P1, $urandom);
            end

            // One phase runs with no idling on either side; one backs up the output.
            gaps_on      = (ph != 4);
            ready_steady = (ph == 4);
            if (ph == 6)
                hold_request = 1'b1;

            phase_start = sent_items;
            if (ph == 2)
                run_reading(1'b1);
            while (sent_items - phase_start < PHASE_ITEMS)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 8)
                    send_item(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                              8'($urandom));
                else if (pick < 12)
                    send_item(gpt_pkg::FUNC_TICK, 1'($urandom_range(1, 0)), 8'($urandom));
                run_reading(1'b0);
            end
        end

        drain();
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
